### design/lsdd_pkg.sv
// ----------------------------------------------------------------------------
// Seeded deck deal package
// Shared constants for the generator, the draw field and the result fields.
// ----------------------------------------------------------------------------
package lsdd_pkg;

  localparam int SEED_W   = 15;
  localparam int LCG_W    = 32;
  localparam int DRAW_W   = 15;
  localparam int DRAW_LSB = 16;
  localparam int CODE_W   = 6;
  localparam int COL_W    = 3;
  localparam int ROW_W    = 3;

  localparam logic [LCG_W-1:0] LCG_MUL = 32'd214013;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'd2531011;

endpackage

### design/lsdd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lsdd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 52
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/lsdd_mod.sv
// ----------------------------------------------------------------------------
// Draw modulo unit
// Restoring remainder of the draw by the card count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lsdd_mod #(
  parameter int DW = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lsdd_pkg::DRAW_W-1:0] dividend_i,
  input  logic [DW-1:0]             divisor_i,
  output logic                      done_o,
  output logic [DW-1:0]             rem_o
);

  localparam int NW = $clog2(lsdd_pkg::DRAW_W + 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [NW-1:0]               cnt_q, cnt_d;
  logic [lsdd_pkg::DRAW_W-1:0] num_q, num_d;
  logic [DW-1:0]               rem_q, rem_d;
  logic [DW-1:0]               den_q, den_d;
  logic [DW:0]                 trial;
  logic [DW:0]                 diff;

  // Bring down the next dividend bit and subtract if the divisor fits.
  assign trial = {rem_q, num_q[lsdd_pkg::DRAW_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = NW'(lsdd_pkg::DRAW_W);
      num_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[lsdd_pkg::DRAW_W-2:0], 1'b0};
      rem_d = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### design/lcg_seeded_deck_deal_top.sv
// ----------------------------------------------------------------------------
// Seeded deck deal
// Deals a whole deck from a deal number using a seeded generator and a
// swap-with-last permutation table.
// ----------------------------------------------------------------------------
// Usage: one input transaction carries a 15-bit deal number. The block then
// returns DECK_SIZE output transactions, one per card in deal order, each
// with the card code, its column and row, and a flag on the final card.
// While a deal is in progress in_stall_o is high; it drops once the final
// card has been written to the output register.
// Each card takes one generator step, a state to start the remainder
// unit, the remainder itself (one bit a cycle), a state to take the
// result, then two table reads through the single read port of the RAM
// and a table write through its write port.
// When the receiver stalls, the card waits in the output register and the
// block holds before writing the next card.
// Reset returns the block to idle with no result pending; the card table
// is marked unwritten at every deal, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module lcg_seeded_deck_deal_top #(
  parameter int DECK_SIZE = 52,
  parameter int COLUMNS   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lsdd_pkg::SEED_W-1:0] deal_seed_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lsdd_pkg::CODE_W-1:0] card_code_o,
  output logic [lsdd_pkg::COL_W-1:0]  column_o,
  output logic [lsdd_pkg::ROW_W-1:0]  row_o,
  output logic                        last_card_o
);

  localparam int AW = $clog2(DECK_SIZE);
  localparam int CW = $clog2(DECK_SIZE + 1);
  localparam int KW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CODE_W = lsdd_pkg::CODE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LCG   = 3'd1;
  localparam logic [2:0] S_MODGO = 3'd2;
  localparam logic [2:0] S_MODW  = 3'd3;
  localparam logic [2:0] S_RDP   = 3'd4;
  localparam logic [2:0] S_RDL   = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [lsdd_pkg::LCG_W-1:0] lcg_q, lcg_d;
  logic [CW-1:0]              left_q, left_d;
  logic [CW-1:0]              pos_q, pos_d;
  logic [KW-1:0]              col_q, col_d;
  logic [lsdd_pkg::ROW_W-1:0] row_q, row_d;
  logic [AW-1:0]              pick_q, pick_d;
  logic [CODE_W-1:0]          card_q, card_d;
  logic [DECK_SIZE-1:0]       vld_q, vld_d;

  logic                       out_valid_q, out_valid_d;
  logic [CODE_W-1:0]          code_out_q, code_out_d;
  logic [lsdd_pkg::COL_W-1:0] col_out_q, col_out_d;
  logic [lsdd_pkg::ROW_W-1:0] row_out_q, row_out_d;
  logic                       last_out_q, last_out_d;

  logic                       accept;
  logic                       out_free;
  logic                       is_last;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              ram_raddr;
  logic [CODE_W-1:0]          ram_rdata;
  logic                       ram_we;
  logic [CODE_W-1:0]          fill_val;
  logic                       mod_start;
  logic                       mod_done;
  logic [CW-1:0]              mod_rem;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_last   = (pos_q == CW'(DECK_SIZE - 1));
  assign last_idx  = AW'(left_q - CW'(1));
  // The last entry stays addressed while the write waits for the output.
  assign ram_raddr = ((state_q == S_RDL) || (state_q == S_WR)) ? last_idx : pick_q;
  assign mod_start = (state_q == S_MODGO);
  // An entry not yet written in this deal stands for its own index.
  assign fill_val  = vld_q[last_idx] ? ram_rdata : CODE_W'(last_idx);

  lsdd_mod #(
    .DW(CW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(lcg_q[lsdd_pkg::DRAW_LSB +: lsdd_pkg::DRAW_W]),
    .divisor_i (left_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  lsdd_ram #(
    .WIDTH(CODE_W),
    .DEPTH(DECK_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pick_q),
    .wdata_i(fill_val),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    lcg_d       = lcg_q;
    left_d      = left_q;
    pos_d       = pos_q;
    col_d       = col_q;
    row_d       = row_q;
    pick_d      = pick_q;
    card_d      = card_q;
    vld_d       = vld_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    code_out_d  = code_out_q;
    col_out_d   = col_out_q;
    row_out_d   = row_out_q;
    last_out_d  = last_out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          lcg_d   = lsdd_pkg::LCG_W'(deal_seed_i);
          left_d  = CW'(DECK_SIZE);
          pos_d   = '0;
          col_d   = '0;
          row_d   = '0;
          vld_d   = '0;
          state_d = S_LCG;
        end
      end
      S_LCG: begin
        lcg_d   = lcg_q * lsdd_pkg::LCG_MUL + lsdd_pkg::LCG_ADD;
        state_d = S_MODGO;
      end
      S_MODGO: begin
        state_d = S_MODW;
      end
      S_MODW: begin
        if (mod_done) begin
          pick_d  = AW'(mod_rem);
          state_d = S_RDP;
        end
      end
      S_RDP: begin
        state_d = S_RDL;
      end
      S_RDL: begin
        card_d  = vld_q[pick_q] ? ram_rdata : CODE_W'(pick_q);
        state_d = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          code_out_d     = card_q;
          col_out_d      = lsdd_pkg::COL_W'(col_q);
          row_out_d      = row_q;
          last_out_d     = is_last;
          ram_we         = 1'b1;
          vld_d[pick_q]  = 1'b1;
          left_d         = left_q - CW'(1);
          pos_d          = pos_q + CW'(1);
          if (col_q == KW'(COLUMNS - 1)) begin
            col_d = '0;
            row_d = row_q + lsdd_pkg::ROW_W'(1);
          end else begin
            col_d = col_q + KW'(1);
          end
          state_d = is_last ? S_IDLE : S_LCG;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcg_q       <= '0;
      left_q      <= '0;
      pos_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    row_q      <= row_d;
    pick_q     <= pick_d;
    card_q     <= card_d;
    code_out_q <= code_out_d;
    col_out_q  <= col_out_d;
    row_out_q  <= row_out_d;
    last_out_q <= last_out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign card_code_o = code_out_q;
  assign column_o    = col_out_q;
  assign row_o       = row_out_q;
  assign last_card_o = last_out_q;

endmodule

### design/lsdd_checker.sv
// ----------------------------------------------------------------------------
// Seeded deck deal checker
// Port-level properties of the deal block, bound to the top level.
// ----------------------------------------------------------------------------
module lsdd_checker #(
  parameter int DECK_SIZE = 52,
  parameter int COLUMNS   = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lsdd_pkg::CODE_W-1:0] card_code_o,
  input logic [lsdd_pkg::COL_W-1:0]  column_o,
  input logic [lsdd_pkg::ROW_W-1:0]  row_o,
  input logic                        last_card_o
);

  localparam logic [lsdd_pkg::COL_W-1:0] LAST_COL =
    lsdd_pkg::COL_W'((DECK_SIZE - 1) % COLUMNS);
  localparam logic [lsdd_pkg::ROW_W-1:0] LAST_ROW =
    lsdd_pkg::ROW_W'((DECK_SIZE - 1) / COLUMNS);

  // A stalled card holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(card_code_o)
      && $stable(last_card_o))
    else $error("stalled card changed");

  // Once a deal number is taken the block is busy dealing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after a deal was accepted");

  // A new card only appears while a deal is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("card produced while idle");

  // The final card sits at the last position of the layout and is a real card.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_card_o |-> column_o == LAST_COL && row_o == LAST_ROW
      && card_code_o < lsdd_pkg::CODE_W'(DECK_SIZE - 1) + 1'b1)
    else $error("final card at wrong position or out of range");

endmodule

bind lcg_seeded_deck_deal_top lsdd_checker #(
  .DECK_SIZE(DECK_SIZE),
  .COLUMNS  (COLUMNS)
) u_lsdd_checker (.*);
